// ===== rtl/core/pkst_pkg.sv =====
`default_nettype none

package pkst_pkg;

   localparam int PEER_ENTRIES_DEFAULT = 64;
   localparam int MAX_SEQUENCE = 8;
   localparam int POS_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE_FLAGS       = 3'd0,
      CSR_SEQUENCE_LENGTH  = 3'd1,
      CSR_TIME_LIMIT       = 3'd2,
      CSR_PORTS_FIRST_FOUR = 3'd3,
      CSR_PORTS_LAST_FOUR  = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      OC_UNTRACKED   = 3'd0,
      OC_KNOCK_OK    = 3'd1,
      OC_KNOCK_WRONG = 3'd2,
      OC_ALLOWED     = 3'd3,
      OC_EXPIRED     = 3'd4,
      OC_TABLE_FULL  = 3'd5,
      OC_NOT_TCP_UDP = 3'd6
   } outcome_type;

   localparam int MODE_RECORD = 0;
   localparam int MODE_CHECK  = 1;
   localparam int MODE_TIMED  = 2;

   typedef struct packed {
      logic [31:0] source_address;
      logic [7:0]  ip_protocol;
      logic [15:0] destination_port;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic       accept;
      logic [2:0] outcome;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [31:0]      address;
      logic             allowed;
      logic [POS_W-1:0] next_position;
      logic [31:0]      last_time;
   } entry_type;

   typedef struct packed {
      logic clear_en;
      logic load;
      logic read_en;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic idx_last;
      logic proto_ok;
   } dp_status_type;

   // Clamp the programmed length into 1..MAX_SEQUENCE.
   function automatic logic [POS_W-1:0] clamp_length(input logic [POS_W-1:0] raw);
      logic [POS_W-1:0] len;
      len = raw;
      if (raw == '0) begin
         len = POS_W'(1);
      end else if (raw > POS_W'(MAX_SEQUENCE)) begin
         len = POS_W'(MAX_SEQUENCE);
      end
      return len;
   endfunction

   function automatic logic [15:0] seq_port(input logic [63:0] first_four,
                                            input logic [63:0] last_four,
                                            input logic [2:0]  idx);
      logic [63:0] word;
      word = idx[2] ? last_four : first_four;
      return word[{idx[1:0], 4'b0000} +: 16];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pkst_ram.sv =====
`default_nettype none

module pkst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pkst_ctrl.sv =====
`default_nettype none

module pkst_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire pkst_pkg::dp_status_type status,
   output pkst_pkg::ctrl_cmd_type       cmd
);

   import pkst_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_DECIDE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_busy;

   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // skip the table walk for anything but TCP or UDP
            if (status.proto_ok) begin
               cmd.read_en = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // hold until the output register frees up
            if (!out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/pkst_dp.sv =====
`default_nettype none

module pkst_dp #(
   parameter int PEER_ENTRIES = pkst_pkg::PEER_ENTRIES_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [pkst_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pkst_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  wire pkst_pkg::req_type                     req_data,
   output pkst_pkg::rsp_type                          rsp_data,
   input  wire pkst_pkg::ctrl_cmd_type                cmd,
   output pkst_pkg::dp_status_type                    status
);

   import pkst_pkg::*;

   localparam int IdxW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
   localparam int EntryW = $bits(entry_type);

   // configuration
   logic [2:0]       mode_ff;
   logic [POS_W-1:0] seq_len_ff;
   logic [31:0]      time_limit_ff;
   logic [63:0]      ports_lo_ff;
   logic [63:0]      ports_hi_ff;

   // request and scan state
   req_type          req_ff;
   logic [IdxW-1:0]  idx_ff;
   logic             eval_valid_ff;
   logic [IdxW-1:0]  eval_idx_ff;
   logic             hit_found_ff;
   logic [IdxW-1:0]  hit_idx_ff;
   entry_type        hit_entry_ff;
   logic             free_found_ff;
   logic [IdxW-1:0]  free_idx_ff;
   rsp_type          rsp_ff;

   // table port
   logic             ram_wr_en;
   logic [IdxW-1:0]  ram_wr_addr;
   entry_type        ram_wr_entry;
   logic [EntryW-1:0] ram_rd_data;
   entry_type        rd_entry;

   // decision
   logic             dec_write;
   logic [IdxW-1:0]  dec_addr;
   entry_type        dec_entry;
   rsp_type          dec_rsp;
   logic [POS_W-1:0] len;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] pos_next;
   logic [32:0]      deadline;
   logic             expired;
   logic             knock_bad;

   assign rd_entry = entry_type'(ram_rd_data);

   assign status.idx_last = (idx_ff == IdxW'(PEER_ENTRIES - 1));
   assign status.proto_ok = (req_ff.ip_protocol == PROTO_TCP) ||
                            (req_ff.ip_protocol == PROTO_UDP);

   assign rsp_data = rsp_ff;

   pkst_ram #(
      .WIDTH (EntryW),
      .DEPTH (PEER_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (EntryW'(ram_wr_entry)),
      .rd_en   (cmd.read_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         seq_len_ff    <= POS_W'(1);
         time_limit_ff <= '0;
         ports_lo_ff   <= '0;
         ports_hi_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE_FLAGS:       mode_ff       <= csr_write_data[2:0];
            CSR_SEQUENCE_LENGTH:  seq_len_ff    <= csr_write_data[POS_W-1:0];
            CSR_TIME_LIMIT:       time_limit_ff <= csr_write_data[31:0];
            CSR_PORTS_FIRST_FOUR: ports_lo_ff   <= csr_write_data;
            CSR_PORTS_LAST_FOUR:  ports_hi_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // walk index, shared by the clearing pass and the lookup scan
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         eval_valid_ff <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (cmd.clear_en || cmd.read_en) begin
            idx_ff <= idx_ff + 1'b1;
         end
         eval_valid_ff <= cmd.read_en;
         if (cmd.load) begin
            hit_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (eval_valid_ff) begin
            // keep the lowest matching entry and the lowest free slot
            if (rd_entry.valid && rd_entry.address == req_ff.source_address &&
                !hit_found_ff) begin
               hit_found_ff <= 1'b1;
            end
            if (!rd_entry.valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= idx_ff;
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (eval_valid_ff && !hit_found_ff && rd_entry.valid &&
          rd_entry.address == req_ff.source_address) begin
         hit_idx_ff   <= eval_idx_ff;
         hit_entry_ff <= rd_entry;
      end
      if (eval_valid_ff && !free_found_ff && !rd_entry.valid) begin
         free_idx_ff <= eval_idx_ff;
      end
      if (cmd.commit) begin
         rsp_ff <= dec_rsp;
      end
   end

   always_comb begin
      len       = clamp_length(seq_len_ff);
      pos       = hit_entry_ff.next_position;
      pos_next  = pos + 1'b1;
      deadline  = {1'b0, hit_entry_ff.last_time} + {1'b0, time_limit_ff};
      expired   = {1'b0, req_ff.now_seconds} > deadline;
      knock_bad = hit_entry_ff.allowed || (pos >= len) ||
                  (req_ff.destination_port != seq_port(ports_lo_ff, ports_hi_ff, pos[2:0]));

      dec_write       = 1'b0;
      dec_addr        = hit_idx_ff;
      dec_entry       = hit_entry_ff;
      dec_rsp.accept  = 1'b0;
      dec_rsp.outcome = OC_UNTRACKED;

      if (!status.proto_ok) begin
         dec_rsp.outcome = OC_NOT_TCP_UDP;
      end else if (mode_ff[MODE_RECORD]) begin
         if (!hit_found_ff) begin
            if (req_ff.destination_port != seq_port(ports_lo_ff, ports_hi_ff, 3'd0)) begin
               dec_rsp.outcome = OC_UNTRACKED;
            end else if (!free_found_ff) begin
               dec_rsp.outcome = OC_TABLE_FULL;
            end else begin
               dec_write               = 1'b1;
               dec_addr                = free_idx_ff;
               dec_entry.valid         = 1'b1;
               dec_entry.address       = req_ff.source_address;
               dec_entry.allowed       = (len == POS_W'(1));
               dec_entry.next_position = POS_W'(1);
               dec_entry.last_time     = req_ff.now_seconds;
               dec_rsp.accept          = 1'b1;
               dec_rsp.outcome         = OC_KNOCK_OK;
            end
         end else if (knock_bad) begin
            dec_rsp.outcome = OC_KNOCK_WRONG;
         end else begin
            dec_write               = 1'b1;
            dec_entry.next_position = pos_next;
            dec_entry.allowed       = (pos_next == len);
            dec_rsp.accept          = 1'b1;
            dec_rsp.outcome         = OC_KNOCK_OK;
            if (mode_ff[MODE_TIMED]) begin
               if (expired) begin
                  // drop the entry, still counts as a match
                  dec_entry.valid = 1'b0;
                  dec_rsp.outcome = OC_EXPIRED;
               end else begin
                  dec_entry.last_time = req_ff.now_seconds;
               end
            end
         end
      end else if (mode_ff[MODE_CHECK]) begin
         if (hit_found_ff && hit_entry_ff.allowed) begin
            dec_rsp.accept  = 1'b1;
            dec_rsp.outcome = OC_ALLOWED;
         end
      end
   end

   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = dec_addr;
      ram_wr_entry = dec_entry;
      if (cmd.clear_en) begin
         ram_wr_en    = 1'b1;
         ram_wr_addr  = idx_ff;
         ram_wr_entry = '0;
      end else if (cmd.commit && dec_write) begin
         ram_wr_en = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/port_knock_sequence_tracker.sv =====
`default_nettype none

// Channel   Ports                          Direction  Beat
// request   req_valid/req_ready/req_data   in         one packet
// response  rsp_valid/rsp_ready/rsp_data   out        accept flag and outcome code
// config    csr_write_enable/csr_index/    in         one register write, no wait
//           csr_write_data
//
// A TCP or UDP packet is accepted, then every entry is read in turn through the single
// read port of the peer table, the last read returns, and the packet is decided and
// written back. Other protocols skip the table reads. After reset the peer table is
// swept clear, entry by entry, with req_ready low.
// The response sits in an output register; the next packet is accepted and scanned while
// it waits, and only the decision and write-back hold until that register is taken.

module port_knock_sequence_tracker #(
   parameter int PEER_ENTRIES = pkst_pkg::PEER_ENTRIES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire pkst_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output pkst_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_write_enable,
   input  wire logic [pkst_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [pkst_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   import pkst_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   pkst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pkst_dp #(
      .PEER_ENTRIES (PEER_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .status           (status)
   );

   a_one_packet_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a packet is in flight");

   a_table_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_en, cmd.read_en, cmd.commit, cmd.load}))
      else $error("conflicting table commands");

   a_commit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("result overwrote an unconsumed response");

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

endmodule

`default_nettype wire
